FILE: hdl/wbmp_pkg.sv
// Shared constants, codes and types for the WBMP header parser.
package wbmp_pkg;

  // Largest dimension accepted, in pixels
  localparam int unsigned MAX_DIMENSION = 65535;

  // Parse phases
  localparam logic [2:0] PH_TYPE   = 3'd0;
  localparam logic [2:0] PH_FIXED  = 3'd1;
  localparam logic [2:0] PH_WIDTH  = 3'd2;
  localparam logic [2:0] PH_HEIGHT = 3'd3;
  localparam logic [2:0] PH_DONE   = 3'd4;

  // Status codes
  localparam logic [2:0] ST_MORE     = 3'd0;
  localparam logic [2:0] ST_OK       = 3'd1;
  localparam logic [2:0] ST_BADTYPE  = 3'd2;
  localparam logic [2:0] ST_BADFIXED = 3'd3;
  localparam logic [2:0] ST_OVERFLOW = 3'd4;
  localparam logic [2:0] ST_RANGE    = 3'd5;

  // Header masks
  localparam logic [63:0] ACC_TOP_MASK = 64'hFE00_0000_0000_0000;
  localparam logic [7:0]  FIXED_MASK   = 8'h9F;
  localparam logic [7:0]  VLQ_DATA     = 8'h7F;
  localparam logic [7:0]  VLQ_CONT     = 8'h80;
  localparam logic [15:0] DIM_MASK     = 16'hFFFF;

  // Parser state carried from one request to the next
  typedef struct packed {
    logic [2:0]  phase;
    logic [63:0] acc;
    logic [15:0] width;
    logic [15:0] height;
    logic [2:0]  fstatus;
  } wbmp_state_t;

  localparam wbmp_state_t STATE_RESET = '{
    phase:   PH_TYPE,
    acc:     64'd0,
    width:   16'd0,
    height:  16'd0,
    fstatus: ST_MORE
  };

endpackage

FILE: hdl/wbmp_in_if.sv
// Input channel: header bytes with a restart flag.
interface wbmp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_in;
  logic       start_image;

  modport source (output valid, output byte_in, output start_image, input ready);
  modport sink   (input valid, input byte_in, input start_image, output ready);
endinterface

FILE: hdl/wbmp_out_if.sv
// Result channel: per-byte status and the parsed dimensions.
interface wbmp_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [15:0] image_width;
  logic [15:0] image_height;
  logic [13:0] row_bytes;

  modport source (output valid, output status, output image_width,
                  output image_height, output row_bytes, input ready);
  modport sink   (input valid, input status, input image_width,
                  input image_height, input row_bytes, output ready);
endinterface

FILE: hdl/wbmp_step.sv
// Next-state logic for one header byte.
module wbmp_step
  import wbmp_pkg::*;
(
  input  wbmp_state_t state_i,
  input  logic [7:0]  byte_i,
  input  logic        start_i,
  output wbmp_state_t state_o
);

  wbmp_state_t cur;
  logic [63:0] acc_sh;
  logic        acc_top;
  logic        dim_bad;

  // Restart clears everything before the byte is parsed
  assign cur     = start_i ? STATE_RESET : state_i;
  assign acc_top = |(cur.acc & ACC_TOP_MASK);
  assign acc_sh  = {cur.acc[56:0], 7'd0} | {56'd0, byte_i & VLQ_DATA};
  assign dim_bad = (acc_sh == 64'd0) || (acc_sh > 64'(MAX_DIMENSION));

  // Advance the phase; a finished parse holds its status
  always_comb begin
    state_o = cur;
    if (cur.fstatus == ST_MORE) begin
      unique case (cur.phase)
        PH_TYPE: begin
          if (byte_i != 8'd0) begin
            state_o.fstatus = ST_BADTYPE;
            state_o.phase   = PH_DONE;
          end else begin
            state_o.phase = PH_FIXED;
          end
        end
        PH_FIXED: begin
          if ((byte_i & FIXED_MASK) != 8'd0) begin
            state_o.fstatus = ST_BADFIXED;
            state_o.phase   = PH_DONE;
          end else begin
            state_o.acc   = 64'd0;
            state_o.phase = PH_WIDTH;
          end
        end
        PH_WIDTH, PH_HEIGHT: begin
          if (acc_top) begin
            state_o.fstatus = ST_OVERFLOW;
            state_o.phase   = PH_DONE;
          end else begin
            state_o.acc = acc_sh;
            if ((byte_i & VLQ_CONT) == 8'd0) begin
              if (dim_bad) begin
                state_o.fstatus = ST_RANGE;
                state_o.phase   = PH_DONE;
              end else begin
                state_o.acc = 64'd0;
                if (cur.phase == PH_WIDTH) begin
                  state_o.width = acc_sh[15:0] & DIM_MASK;
                  state_o.phase = PH_HEIGHT;
                end else begin
                  state_o.height  = acc_sh[15:0] & DIM_MASK;
                  state_o.fstatus = ST_OK;
                  state_o.phase   = PH_DONE;
                end
              end
            end
          end
        end
        default: begin
          state_o = cur;
        end
      endcase
    end
  end

endmodule

FILE: hdl/wbmp_header_parser.sv
// WBMP type-0 header parser, one status per header byte.
// An accepted request's result is loaded into the output register in the following cycle.
// Accepts one byte per cycle unless a stalled result holds the input; the shift-or and range compare are combinational.
// The input stays ready while the output register is empty or being drained.
// Reset (rst_n low, synchronous) returns to the type-byte phase with zero state.
module wbmp_header_parser
  import wbmp_pkg::*;
(
  input logic          clk,
  input logic          rst_n,
  wbmp_in_if.sink      in_ch,
  wbmp_out_if.source   out_ch
);

  wbmp_state_t state_r;
  wbmp_state_t state_nxt;
  logic        out_valid_r;
  logic [2:0]  status_r;
  logic [15:0] width_r;
  logic [15:0] height_r;
  logic [13:0] row_bytes_r;
  logic [16:0] row_sum;
  logic        in_acc;

  // Accept while the output register is free or leaving
  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign in_acc      = in_ch.valid && in_ch.ready;

  wbmp_step u_step (
    .state_i (state_r),
    .byte_i  (in_ch.byte_in),
    .start_i (in_ch.start_image),
    .state_o (state_nxt)
  );

  assign row_sum = {1'b0, state_nxt.width} + 17'd7;

  // Hold parser state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= STATE_RESET;
    end else if (in_acc) begin
      state_r <= state_nxt;
    end
  end

  // Output register valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_acc) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Load the result payload; dimensions show only on a good header
  always_ff @(posedge clk) begin
    if (in_acc) begin
      status_r <= state_nxt.fstatus;
      if (state_nxt.fstatus == ST_OK) begin
        width_r     <= state_nxt.width;
        height_r    <= state_nxt.height;
        row_bytes_r <= row_sum[16:3];
      end else begin
        width_r     <= 16'd0;
        height_r    <= 16'd0;
        row_bytes_r <= 14'd0;
      end
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.status       = status_r;
  assign out_ch.image_width  = width_r;
  assign out_ch.image_height = height_r;
  assign out_ch.row_bytes    = row_bytes_r;

  // A stalled result blocks new requests
  a_stall_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ch.ready) |-> !in_ch.ready)
    else $error("request taken while result stalled");

  // A restart with a nonzero type byte reports bad type
  a_bad_type: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_ch.start_image && (in_ch.byte_in != 8'd0))
      |=> (out_ch.status == ST_BADTYPE))
    else $error("bad type byte not reported");

  // Dimensions stay zero unless the header is good
  a_dims_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (status_r != ST_OK))
      |-> ((width_r == 16'd0) && (height_r == 16'd0) && (row_bytes_r == 14'd0)))
    else $error("dimensions shown without a good header");

  // A final status sticks until restart
  a_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && !in_ch.start_image && (state_r.fstatus != ST_MORE))
      |=> (state_r.fstatus == $past(state_r.fstatus)))
    else $error("final status changed without restart");

endmodule

FILE: test/tb.sv
// Self-checking testbench for the WBMP header parser: directed table plus random headers.
`timescale 1ns / 1ps

module tb;
  import wbmp_pkg::*;

  typedef struct packed {
    logic [2:0]  status;
    logic [15:0] width;
    logic [15:0] height;
    logic [13:0] row_bytes;
  } hdr_result_t;

  typedef struct packed {
    logic [7:0]  b;
    logic        restart;
    logic        typed;
    hdr_result_t res;
  } stim_row_t;

  localparam hdr_result_t R_MORE     = '{ST_MORE, 16'd0, 16'd0, 14'd0};
  localparam hdr_result_t R_OK_MAX   = '{ST_OK, 16'd65535, 16'd1, 14'd8192};
  localparam hdr_result_t R_BADTYPE  = '{ST_BADTYPE, 16'd0, 16'd0, 14'd0};
  localparam hdr_result_t R_BADFIXED = '{ST_BADFIXED, 16'd0, 16'd0, 14'd0};
  localparam hdr_result_t R_RANGE    = '{ST_RANGE, 16'd0, 16'd0, 14'd0};
  localparam hdr_result_t R_OVERFLOW = '{ST_OVERFLOW, 16'd0, 16'd0, 14'd0};

  localparam int DIR_ROWS    = 25;
  localparam int BYTE_TARGET = 1150;
  localparam int HOLD_CYCLES = 300;

  logic clk;
  logic rst_n;

  wbmp_in_if  in_ch ();
  wbmp_out_if out_ch ();

  wbmp_header_parser u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // Predicted parser state and results still awaited from the block
  wbmp_state_t parser_st;
  hdr_result_t awaited_results [$];
  stim_row_t   dir_tab [DIR_ROWS];

  int mismatch_cnt;
  int result_cnt;
  int bytes_counted;
  int burst_left;
  int hdr_n;
  bit hold_req;
  int hold_cnt;
  int rx_cyc;
  int rx_mode;

  always #2 clk = ~clk;

  // Give up after a generous fixed time
  initial begin
    #2_000_000;
    $display("Mismatches found");
    $finish;
  end

  task automatic report_mismatch(input string what, input longint unsigned got,
                                 input longint unsigned want);
    $display("result %0d: %s is 0x%0h, want 0x%0h", result_cnt, what, got, want);
    mismatch_cnt++;
  endtask

  // Advance the predicted parser by one header byte and return its status
  function automatic hdr_result_t predict_header(input logic [7:0] b, input logic restart);
    hdr_result_t r;
    logic [16:0] rb_sum;
    if (restart) parser_st = STATE_RESET;
    if (parser_st.fstatus == ST_MORE) begin
      case (parser_st.phase)
        PH_TYPE: begin
          if (b != 8'h00) begin
            parser_st.fstatus = ST_BADTYPE;
            parser_st.phase   = PH_DONE;
          end else begin
            parser_st.phase = PH_FIXED;
          end
        end
        PH_FIXED: begin
          if ((b & FIXED_MASK) != 8'h00) begin
            parser_st.fstatus = ST_BADFIXED;
            parser_st.phase   = PH_DONE;
          end else begin
            parser_st.acc   = 64'd0;
            parser_st.phase = PH_WIDTH;
          end
        end
        PH_WIDTH, PH_HEIGHT: begin
          if ((parser_st.acc & ACC_TOP_MASK) != 64'd0) begin
            parser_st.fstatus = ST_OVERFLOW;
            parser_st.phase   = PH_DONE;
          end else begin
            parser_st.acc = (parser_st.acc << 7) | {56'd0, b & VLQ_DATA};
            // a clear continuation bit closes the dimension
            if ((b & VLQ_CONT) == 8'h00) begin
              if (parser_st.acc == 64'd0 || parser_st.acc > 64'(MAX_DIMENSION)) begin
                parser_st.fstatus = ST_RANGE;
                parser_st.phase   = PH_DONE;
              end else if (parser_st.phase == PH_WIDTH) begin
                parser_st.width = parser_st.acc[15:0] & DIM_MASK;
                parser_st.acc   = 64'd0;
                parser_st.phase = PH_HEIGHT;
              end else begin
                parser_st.height  = parser_st.acc[15:0] & DIM_MASK;
                parser_st.acc     = 64'd0;
                parser_st.fstatus = ST_OK;
                parser_st.phase   = PH_DONE;
              end
            end
          end
        end
        default: ;
      endcase
    end
    r = R_MORE;
    r.status = parser_st.fstatus;
    if (parser_st.fstatus == ST_OK) begin
      rb_sum      = {1'b0, parser_st.width} + 17'd7;
      r.width     = parser_st.width;
      r.height    = parser_st.height;
      r.row_bytes = rb_sum[16:3];
    end
    return r;
  endfunction

  // Offer one request, wait for its acceptance, then record what it should yield
  task automatic send_req(input logic [7:0] b, input logic restart);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_ch.valid       <= 1'b1;
    in_ch.byte_in     <= b;
    in_ch.start_image <= restart;
    do @(posedge clk); while (!in_ch.ready);
    bytes_counted++;
    awaited_results.push_back(predict_header(b, restart));
  endtask

  // Hold the input idle until every awaited result has been delivered
  task automatic drain_pause;
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (awaited_results.size() != 0);
  endtask

  // One dimension as a variable-length quantity, sometimes malformed
  task automatic send_dim;
    logic [63:0] v;
    int n;
    int pad;
    int mode;
    mode = $urandom_range(0, 9);
    if (mode == 9) begin
      // long run of continuation bytes to drive the accumulator over the top
      send_req(VLQ_CONT | 8'($urandom_range(1, 127)), 1'b0);
      repeat ($urandom_range(8, 10)) send_req(VLQ_CONT | 8'($urandom), 1'b0);
      send_req(8'($urandom) & VLQ_DATA, 1'b0);
    end else begin
      case (mode)
        0, 1, 2, 3, 4: v = 64'($urandom_range(1, 300));
        5:             v = 64'($urandom_range(1, 65535));
        6:             v = 64'(65535 - $urandom_range(0, 1));
        7:             v = 64'd0;
        default:       v = {$urandom, $urandom} >> $urandom_range(0, 47);
      endcase
      pad = ($urandom_range(0, 5) == 0) ? $urandom_range(1, 3) : 0;
      repeat (pad) send_req(VLQ_CONT, 1'b0);
      n = 1;
      while (n < 10 && (v >> (7 * n)) != 64'd0) n++;
      for (int i = n - 1; i >= 0; i--)
        send_req(8'((v >> (7 * i)) & 64'(VLQ_DATA)) | ((i > 0) ? VLQ_CONT : 8'h00), 1'b0);
    end
  endtask

  // A header, mostly well formed, occasionally cut short
  task automatic send_header;
    logic cut;
    cut = ($urandom_range(0, 9) == 0);
    case ($urandom_range(0, 19))
      0:       send_req(8'($urandom_range(1, 255)), 1'b1);
      1:       send_req(8'h00, 1'b0);
      default: send_req(8'h00, 1'b1);
    endcase
    if (cut && $urandom_range(0, 1) == 0) return;
    if ($urandom_range(0, 11) == 0) send_req(8'($urandom), 1'b0);
    else send_req(8'($urandom) & ~FIXED_MASK, 1'b0);
    if (cut && $urandom_range(0, 1) == 0) return;
    send_dim();
    if (cut && $urandom_range(0, 1) == 0) return;
    send_dim();
    repeat ($urandom_range(0, 2)) send_req(8'($urandom), 1'b0);
  endtask

  // Stimulus: reset, directed table, random headers, drain
  initial begin
    clk               = 1'b0;
    rst_n             = 1'b0;
    in_ch.valid       = 1'b0;
    in_ch.byte_in     = 8'h00;
    in_ch.start_image = 1'b0;
    parser_st         = STATE_RESET;
    mismatch_cnt      = 0;
    result_cnt        = 0;
    bytes_counted     = 0;
    burst_left        = 0;
    hold_req          = 1'b0;

    dir_tab = '{
      '{8'h00, 1'b0, 1'b1, R_MORE},       // type byte straight after reset
      '{8'h60, 1'b0, 1'b1, R_MORE},       // fixed byte with both free bits set
      '{8'h83, 1'b0, 1'b0, R_MORE},       // width 65535 in three bytes
      '{8'hFF, 1'b0, 1'b0, R_MORE},
      '{8'h7F, 1'b0, 1'b0, R_MORE},
      '{8'h01, 1'b0, 1'b1, R_OK_MAX},     // height 1: widest row
      '{8'hFF, 1'b0, 1'b1, R_OK_MAX},     // sticky after success
      '{8'h01, 1'b1, 1'b1, R_BADTYPE},    // restart onto a bad type byte
      '{8'h00, 1'b1, 1'b1, R_MORE},
      '{8'hFF, 1'b0, 1'b1, R_BADFIXED},   // every fixed-header bit set
      '{8'h00, 1'b1, 1'b0, R_MORE},
      '{8'h00, 1'b0, 1'b0, R_MORE},
      '{8'h00, 1'b0, 1'b1, R_RANGE},      // zero width
      '{8'h00, 1'b1, 1'b0, R_MORE},
      '{8'h00, 1'b0, 1'b0, R_MORE},
      '{8'hFF, 1'b0, 1'b0, R_MORE},       // nine full continuation bytes
      '{8'hFF, 1'b0, 1'b0, R_MORE},
      '{8'hFF, 1'b0, 1'b0, R_MORE},
      '{8'hFF, 1'b0, 1'b0, R_MORE},
      '{8'hFF, 1'b0, 1'b0, R_MORE},
      '{8'hFF, 1'b0, 1'b0, R_MORE},
      '{8'hFF, 1'b0, 1'b0, R_MORE},
      '{8'hFF, 1'b0, 1'b0, R_MORE},
      '{8'hFF, 1'b0, 1'b0, R_MORE},
      '{8'h00, 1'b0, 1'b1, R_OVERFLOW}    // accumulator full: overflow
    };

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Walk the directed table; typed rows replace the predicted value
    for (int i = 0; i < DIR_ROWS; i++) begin
      send_req(dir_tab[i].b, dir_tab[i].restart);
      if (dir_tab[i].typed) awaited_results[awaited_results.size() - 1] = dir_tab[i].res;
    end

    // Random headers with some noise in between
    hdr_n = 0;
    while (bytes_counted < BYTE_TARGET) begin
      if (hdr_n == 30 || hdr_n == 180) hold_req = 1'b1;
      if (hdr_n % 97 == 60) drain_pause();
      if ($urandom_range(0, 9) == 0) begin
        repeat ($urandom_range(1, 5)) send_req(8'($urandom), 1'($urandom_range(0, 1)));
      end else begin
        send_header();
      end
      hdr_n++;
    end

    in_ch.valid <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatch_cnt == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Receiver: stall on a changing pattern, with long hold-offs on request
  initial begin
    out_ch.ready = 1'b0;
    hold_cnt     = 0;
    rx_cyc       = 0;
    rx_mode      = 0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        hold_cnt = HOLD_CYCLES;
      end
      if (hold_cnt > 0) begin
        hold_cnt--;
        out_ch.ready <= 1'b0;
      end else begin
        rx_cyc++;
        if (rx_cyc % 64 == 0) rx_mode = $urandom_range(0, 3);
        case (rx_mode)
          0:       out_ch.ready <= 1'b1;
          1:       out_ch.ready <= ($urandom_range(0, 3) != 0);
          2:       out_ch.ready <= rx_cyc[0];
          default: out_ch.ready <= 1'($urandom_range(0, 1));
        endcase
      end
    end
  end

  // Check each delivered result against the oldest awaited one
  always @(posedge clk) begin
    hdr_result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (awaited_results.size() == 0) begin
        report_mismatch("unexpected result, status", out_ch.status, 0);
      end else begin
        want = awaited_results.pop_front();
        if (out_ch.status !== want.status)
          report_mismatch("status", out_ch.status, want.status);
        if (out_ch.image_width !== want.width)
          report_mismatch("image_width", out_ch.image_width, want.width);
        if (out_ch.image_height !== want.height)
          report_mismatch("image_height", out_ch.image_height, want.height);
        if (out_ch.row_bytes !== want.row_bytes)
          report_mismatch("row_bytes", out_ch.row_bytes, want.row_bytes);
      end
      result_cnt++;
    end
  end

endmodule

FILE: sim.f
hdl/wbmp_pkg.sv
hdl/wbmp_in_if.sv
hdl/wbmp_out_if.sv
hdl/wbmp_step.sv
hdl/wbmp_header_parser.sv
test/tb.sv
